>>> design/clipped_standardized_row_variance_assert.svh
// Assertion macros for the clipped standardized row variance block.
`ifndef CLIPPED_STANDARDIZED_ROW_VARIANCE_ASSERT_SVH
`define CLIPPED_STANDARDIZED_ROW_VARIANCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CSRV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CSRV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/csrv_pkg.sv
// Shared types and constants of the clipped standardized row variance block.
package csrv_pkg;

    localparam int VAL_W   = 24;
    localparam int COL_W   = 21;
    localparam int CLIP_W  = 26;
    localparam int SUM_W   = 64;
    localparam int RES_W   = 40;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int MAX_COLUMNS_DEFAULT = 1048576;

    localparam logic [COL_W-1:0]  COL_RESET  = 21'd1;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 26'd65536;

    // register index, taken from paddr[2]
    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_CLIP_LIMIT   = 1'b1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    // shared divider geometry
    localparam int DREM_W  = 37;
    localparam int DLOW_W  = 40;
    localparam int DSTEP_W = 6;
    localparam logic [DSTEP_W-1:0] Z_STEPS     = 6'd26;
    localparam logic [DSTEP_W-1:0] FINAL_STEPS = 6'd40;

    typedef struct packed {
        logic [VAL_W-1:0] entry_value;
        logic [VAL_W-1:0] row_mean;
        logic [VAL_W-1:0] row_sd;
        logic             has_entry;
        logic             row_end;
    } item_t;

    typedef struct packed {
        logic [RES_W-1:0] row_variance;
        logic             count_overflow;
    } result_t;

    typedef struct packed {
        logic             has_entry;
        logic             row_end;
        logic [VAL_W-1:0] diff;
        logic [VAL_W-1:0] mean;
        logic [VAL_W-1:0] sd;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]  cols;
        logic [CLIP_W-1:0] clip;
    } cfg_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              full;
        logic              empty;
    } qstat_t;

    typedef struct packed {
        logic               start;
        logic [DREM_W-1:0]  rem;
        logic [DREM_W-1:0]  divisor;
        logic [DLOW_W-1:0]  low;
        logic [DSTEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DLOW_W-1:0] quot;
    } div_rsp_t;

endpackage

>>> design/csrv_front.sv
// Front end: accept items, drop empty markers, form the command for the back end.
module csrv_front
    import csrv_pkg::*;
(
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    input  logic  q_full,
    output logic  push,
    output cmd_t  push_cmd
);

    logic [VAL_W-1:0] diff;
    logic [VAL_W-1:0] sd_fix;

    // markers without row end are taken and dropped
    assign item_ready = !q_full;
    assign push       = item_valid && !q_full && (item.has_entry || item.row_end);

    assign diff   = (item.entry_value >= item.row_mean) ? (item.entry_value - item.row_mean)
                                                        : (item.row_mean - item.entry_value);
    // zero sd counts as one LSB
    assign sd_fix = (item.row_sd == '0) ? VAL_W'(1) : item.row_sd;

    assign push_cmd.has_entry = item.has_entry;
    assign push_cmd.row_end   = item.row_end;
    assign push_cmd.diff      = diff;
    assign push_cmd.mean      = item.row_mean;
    assign push_cmd.sd        = sd_fix;

endmodule

>>> design/csrv_queue.sv
// Short command queue between the front and back ends.
module csrv_queue
    import csrv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   push_cmd,
    input  logic   pop,
    output cmd_t   pop_cmd,
    output qstat_t stat
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.level = level_reg;
    assign stat.full  = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign stat.empty = (level_reg == '0);

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/csrv_div.sv
// Shared restoring divider, one quotient bit per cycle.
module csrv_div
    import csrv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DREM_W-1:0]  rem_reg;
    logic [DREM_W-1:0]  dvs_reg;
    logic [DLOW_W-1:0]  low_reg;
    logic [DLOW_W-1:0]  quot_reg;
    logic [DSTEP_W-1:0] left_reg;
    logic               done_reg;
    logic [DREM_W:0]    trial;
    logic               fits;

    // shift the next dividend bit in, subtract where the divisor fits
    assign trial = {rem_reg, low_reg[DLOW_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem;
            dvs_reg  <= req.divisor;
            low_reg  <= req.low;
            quot_reg <= '0;
        end
        else if (left_reg != '0)
        begin
            rem_reg  <= fits ? DREM_W'(trial - {1'b0, dvs_reg}) : DREM_W'(trial);
            low_reg  <= {low_reg[DLOW_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DLOW_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            left_reg <= req.steps;
            done_reg <= 1'b0;
        end
        else if (left_reg != '0)
        begin
            left_reg <= left_reg - 1'b1;
            done_reg <= (left_reg == DSTEP_W'(1));
        end
    end

endmodule

>>> design/csrv_back.sv
// Back end: clipped z squared, accumulation, zero-value term and the final divide.
module csrv_back
    import csrv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     cmd_valid,
    input  cmd_t     cmd,
    output logic     cmd_pop,
    output div_req_t div_req,
    input  div_rsp_t div_rsp,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ZSTART = 4'd1;
    localparam logic [3:0] ST_ZWAIT  = 4'd2;
    localparam logic [3:0] ST_SQUARE = 4'd3;
    localparam logic [3:0] ST_ACC    = 4'd4;
    localparam logic [3:0] ST_MUL_LO = 4'd5;
    localparam logic [3:0] ST_MUL_HI = 4'd6;
    localparam logic [3:0] ST_ZADD   = 4'd7;
    localparam logic [3:0] ST_END    = 4'd8;
    localparam logic [3:0] ST_FINAL  = 4'd9;
    localparam logic [3:0] ST_FWAIT  = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    localparam int SQ_W   = 2 * CLIP_W;
    localparam int PROD_W = COL_W + CLIP_W;
    localparam int TERM_W = COL_W + SQ_W;

    logic [3:0]        state_reg,  state_next;
    cmd_t              cmd_reg,    cmd_next;
    logic [VAL_W-1:0]  num_reg,    num_next;
    logic              zphase_reg, zphase_next;
    logic [CLIP_W-1:0] mag_reg,    mag_next;
    logic [SQ_W-1:0]   sq_reg,     sq_next;
    logic [COL_W-1:0]  zeros_reg,  zeros_next;
    logic [TERM_W-1:0] term_reg,   term_next;
    logic [SUM_W-1:0]  sum_reg,    sum_next;
    logic [COL_W-1:0]  count_reg,  count_next;
    logic              excess_reg, excess_next;
    logic              ovf_reg,    ovf_next;
    logic [RES_W-1:0]  var_reg,    var_next;
    logic              rvalid_reg, rvalid_next;
    result_t           res_reg,    res_next;

    logic              z_big;
    logic [CLIP_W-1:0] q_z;
    logic [CLIP_W-1:0] mul_sel;
    logic [PROD_W-1:0] prod;
    logic [SQ_W-1:0]   square;
    logic [SUM_W-1:0]  addend;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [COL_W-1:0]  cols_m1;
    logic              final_big;

    assign result_valid = rvalid_reg;
    assign result       = res_reg;

    // quotient reaches 2^26 or more: it clips whatever clip_limit holds
    assign z_big  = ({10'b0, num_reg} >= {cmd_reg.sd, 10'b0});
    assign q_z    = div_rsp.quot[CLIP_W-1:0];
    assign square = {{CLIP_W{1'b0}}, mag_reg} * {{CLIP_W{1'b0}}, mag_reg};

    assign mul_sel = (state_reg == ST_MUL_LO) ? sq_reg[CLIP_W-1:0] : sq_reg[SQ_W-1:CLIP_W];
    assign prod    = {{CLIP_W{1'b0}}, zeros_reg} * {{COL_W{1'b0}}, mul_sel};

    assign addend   = (state_reg == ST_ZADD)
                    ? ((term_reg[TERM_W-1:SUM_W] != '0) ? {SUM_W{1'b1}} : term_reg[SUM_W-1:0])
                    : {{(SUM_W-SQ_W){1'b0}}, sq_reg};
    assign sum_wide = {1'b0, sum_reg} + {1'b0, addend};
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    assign cols_m1   = cfg.cols - 1'b1;
    // quotient would need more than 40 bits
    assign final_big = ({13'b0, sum_reg} >= {cols_m1, 56'b0});

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        num_next    = num_reg;
        zphase_next = zphase_reg;
        mag_next    = mag_reg;
        sq_next     = sq_reg;
        zeros_next  = zeros_reg;
        term_next   = term_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        excess_next = excess_reg;
        ovf_next    = ovf_reg;
        var_next    = var_reg;
        rvalid_next = rvalid_reg;
        res_next    = res_reg;
        cmd_pop     = 1'b0;
        div_req     = '0;

        if (rvalid_reg && result_ready)
        begin
            rvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd;
                    num_next    = cmd.diff;
                    zphase_next = 1'b0;
                    state_next  = cmd.has_entry ? ST_ZSTART : ST_END;
                end
            end
            ST_ZSTART:
            begin
                if (z_big)
                begin
                    mag_next   = cfg.clip;
                    state_next = ST_SQUARE;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.rem     = {23'b0, num_reg[VAL_W-1:10]};
                    div_req.divisor = {13'b0, cmd_reg.sd};
                    div_req.low     = {num_reg[9:0], 30'b0};
                    div_req.steps   = Z_STEPS;
                    state_next      = ST_ZWAIT;
                end
            end
            ST_ZWAIT:
            begin
                if (div_rsp.done)
                begin
                    mag_next   = (q_z > cfg.clip) ? cfg.clip : q_z;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                sq_next    = square;
                state_next = zphase_reg ? ST_MUL_LO : ST_ACC;
            end
            ST_ACC:
            begin
                sum_next = sum_sat;
                if (count_reg >= cfg.cols)
                begin
                    excess_next = 1'b1;
                end
                if (count_reg != {COL_W{1'b1}})
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = cmd_reg.row_end ? ST_END : ST_IDLE;
            end
            ST_MUL_LO:
            begin
                term_next  = {{(TERM_W-PROD_W){1'b0}}, prod};
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                term_next  = term_reg + {prod, {CLIP_W{1'b0}}};
                state_next = ST_ZADD;
            end
            ST_ZADD:
            begin
                sum_next   = sum_sat;
                state_next = ST_FINAL;
            end
            ST_END:
            begin
                ovf_next = excess_reg || (count_reg > cfg.cols);
                if (!excess_reg && (count_reg < cfg.cols))
                begin
                    num_next    = cmd_reg.mean;
                    zeros_next  = cfg.cols - count_reg;
                    zphase_next = 1'b1;
                    state_next  = ST_ZSTART;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (cfg.cols <= COL_W'(1))
                begin
                    var_next   = '0;
                    state_next = ST_OUT;
                end
                else if (final_big)
                begin
                    var_next   = {RES_W{1'b1}};
                    state_next = ST_OUT;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.rem     = {13'b0, sum_reg[SUM_W-1:RES_W]};
                    div_req.divisor = {cols_m1, 16'b0};
                    div_req.low     = sum_reg[RES_W-1:0];
                    div_req.steps   = FINAL_STEPS;
                    state_next      = ST_FWAIT;
                end
            end
            ST_FWAIT:
            begin
                if (div_rsp.done)
                begin
                    var_next   = div_rsp.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rvalid_reg || result_ready)
                begin
                    res_next.row_variance   = var_reg;
                    res_next.count_overflow = ovf_reg;
                    rvalid_next             = 1'b1;
                    sum_next                = '0;
                    count_next              = '0;
                    excess_next             = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        num_reg    <= num_next;
        zphase_reg <= zphase_next;
        mag_reg    <= mag_next;
        sq_reg     <= sq_next;
        zeros_reg  <= zeros_next;
        term_reg   <= term_next;
        ovf_reg    <= ovf_next;
        var_reg    <= var_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sum_reg    <= '0;
            count_reg  <= '0;
            excess_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            excess_reg <= excess_next;
            rvalid_reg <= rvalid_next;
        end
    end

endmodule

>>> design/clipped_standardized_row_variance.sv
// Top level of the clipped standardized row variance block: registers, front, queue, back.
//
//  channel  | role   | handshake                       | payload
//  ---------+--------+---------------------------------+-------------------------
//  item     | input  | item_valid / item_ready         | item_t (entry, mean, sd)
//  result   | output | result_valid / result_ready     | result_t (variance, ovf)
//  apb      | config | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// An entry may wait in the back end on the shared one-bit-per-cycle divider
// for |z|; a row end adds the zero-value term and the final divide by
// (columns - 1) and the output load.
// The front takes a transaction each cycle while the four-deep queue has room;
// a result holds in its output register until taken and the back end waits behind it.
// Reset clears the queue, the accumulators and the output valid; no clearing pass.

`include "clipped_standardized_row_variance_assert.svh"

module clipped_standardized_row_variance
    import csrv_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,

    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    localparam logic [24:0] MaxCols = 25'(MAX_COLUMNS);

    logic [COL_W-1:0]  column_count_reg;
    logic [CLIP_W-1:0] clip_limit_reg;
    logic              cfg_write;
    cfg_t              cfg;

    logic              push;
    cmd_t              push_cmd;
    logic              pop;
    cmd_t              pop_cmd;
    qstat_t            qstat;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // APB: zero wait states, register picked by paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_COLUMN_COUNT: prdata = {{(DATA_W-COL_W){1'b0}}, column_count_reg};
            REG_CLIP_LIMIT:   prdata = {{(DATA_W-CLIP_W){1'b0}}, clip_limit_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COL_RESET;
            clip_limit_reg   <= CLIP_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_COLUMN_COUNT: column_count_reg <= pwdata[COL_W-1:0];
                REG_CLIP_LIMIT:   clip_limit_reg   <= pwdata[CLIP_W-1:0];
                default:          column_count_reg <= column_count_reg;
            endcase
        end
    end

    // limit the column count to what the design is built for
    assign cfg.cols = ({4'b0, column_count_reg} > MaxCols) ? MaxCols[COL_W-1:0]
                                                             : column_count_reg;
    assign cfg.clip = clip_limit_reg;

    csrv_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (qstat.full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    csrv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (qstat)
    );

    csrv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    csrv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (!qstat.empty),
        .cmd          (pop_cmd),
        .cmd_pop      (pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // queue occupancy never passes its depth
    `CSRV_ASSERT_NOW(a_queue_level, 1'b1, qstat.level <= QLVL_W'(QUEUE_DEPTH), "queue overrun")

    // a taken entry or row end is waiting in the queue or already popped
    `CSRV_ASSERT_NEXT(a_cmd_queued, push && !pop, !qstat.empty, "command lost at the queue")

    // one column or none gives a zero variance
    `CSRV_ASSERT_NOW(a_single_column, result_valid && (cfg.cols <= COL_W'(1)),
        result.row_variance == '0, "nonzero variance with at most one column")

endmodule

>>> tb/sv/clipped_standardized_row_variance_test.sv
// Testbench for the clipped standardized row variance block: directed and random rows, scoreboarded.
module clipped_standardized_row_variance_test;
    import csrv_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    // Leave ample slack after the last result for markers that are still in
    // flight but produce no result.
    localparam int SETTLE_CYCLES = 300;
    localparam int IDLE_PCT      = 22;
    localparam int MAX_SHOWN     = 40;
    // Overall time limit, set well above the slowest correct run.
    localparam int RUN_LIMIT     = 6_000_000;

    localparam logic [SUM_W-1:0]  SUM_MAX      = '1;
    localparam logic [SUM_W-1:0]  VARIANCE_MAX = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [COL_W-1:0]  COLS_TOP     = '1;
    localparam logic [CLIP_W-1:0] CLIP_TOP     = '1;
    localparam logic [VAL_W-1:0]  VAL_TOP      = '1;

    // Drive every input to a known value from time zero.
    logic              clk;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result;

    // Predictor copy of the block's registers and row accumulators.
    logic [SUM_W-1:0]  model_sum     = '0;
    logic [COL_W-1:0]  model_count   = '0;
    logic              model_excess  = 1'b0;
    logic [COL_W-1:0]  model_columns = COL_RESET;
    logic [CLIP_W-1:0] model_clip    = CLIP_RESET;

    // Row results still owed by the block, oldest first.
    result_t           pending_rows[$];
    result_t           oldest_row;

    // When set, neither side inserts idle cycles.
    logic              steady = 1'b0;

    int unsigned items_sent     = 0;
    int unsigned rows_predicted = 0;
    int unsigned overflow_rows  = 0;
    int unsigned saturated_rows = 0;
    int unsigned settings_used  = 0;
    int unsigned rows_checked   = 0;
    int unsigned mismatches     = 0;

    clipped_standardized_row_variance u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a, b);
        logic [SUM_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    // |value - mean| / sd in Q.16, limited to the clip bound, then squared (Q.32).
    // A zero sd counts as one LSB.
    function automatic logic [SUM_W-1:0] clipped_z_sq(input logic [VAL_W-1:0] value, mean, sd);
        logic [VAL_W-1:0]    diff;
        logic [VAL_W-1:0]    den;
        logic [VAL_W+15:0]   mag;
        logic [SUM_W-1:0]    wide;
        diff = (value >= mean) ? value - mean : mean - value;
        den  = (sd == '0) ? VAL_W'(1) : sd;
        mag  = {diff, 16'h0000} / den;
        if (mag > model_clip)
        begin
            mag = model_clip;
        end
        wide = mag;
        return wide * wide;
    endfunction

    // Advance the predictor by one accepted transaction; queue a result on a row end.
    task automatic accumulate_item(input item_t it);
        logic [SUM_W-1:0]   cols;
        logic [SUM_W-1:0]   z0_sq;
        logic [2*SUM_W-1:0] zero_term;
        logic [SUM_W-1:0]   quotient;
        logic               overflow;
        result_t            row;
        // Column counts above the supported maximum are used as the maximum.
        cols = (model_columns > MAX_COLUMNS_DEFAULT) ? MAX_COLUMNS_DEFAULT : model_columns;
        if (it.has_entry)
        begin
            model_sum = sat_add(model_sum, clipped_z_sq(it.entry_value, it.row_mean, it.row_sd));
            if (model_count >= cols)
            begin
                model_excess = 1'b1;
            end
            if (model_count != COLS_TOP)
            begin
                model_count = model_count + 1'b1;
            end
        end
        if (it.row_end)
        begin
            overflow = model_excess || (model_count > cols);
            // Missing columns are zeros; their term uses the mean and sd of the
            // row-end transaction and is dropped once the row overflowed.
            if (!overflow && model_count < cols)
            begin
                z0_sq     = clipped_z_sq('0, it.row_mean, it.row_sd);
                zero_term = (cols - model_count) * z0_sq;
                model_sum = sat_add(model_sum, (zero_term[2*SUM_W-1:SUM_W] != '0) ?
                                               SUM_MAX : zero_term[SUM_W-1:0]);
            end
            row.row_variance = '0;
            if (cols > 1)
            begin
                quotient = (model_sum / (cols - 1)) >> 16;
                if (quotient > VARIANCE_MAX)
                begin
                    quotient = VARIANCE_MAX;
                    saturated_rows++;
                end
                row.row_variance = quotient[RES_W-1:0];
            end
            row.count_overflow = overflow;
            pending_rows.push_back(row);
            rows_predicted++;
            if (overflow)
            begin
                overflow_rows++;
            end
            model_sum    = '0;
            model_count  = '0;
            model_excess = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one transaction: idle at random, raise valid, hold until accepted.
    task automatic send_item(input item_t it);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        accumulate_item(it);
        if (it.has_entry || it.row_end)
        begin
            items_sent++;
        end
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every owed row result has been taken.
    task automatic wait_rows_done();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen high.
    task automatic write_register(input logic idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_COLUMN_COUNT)
        begin
            model_columns = data[COL_W-1:0];
        end
        else
        begin
            model_clip = data[CLIP_W-1:0];
        end
    endtask

    // Reprogram only with the block idle: drain results, let trailing markers
    // clear the pipeline, then write both registers.
    task automatic configure(input logic [COL_W-1:0] cols, input logic [CLIP_W-1:0] clip);
        wait_rows_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(REG_COLUMN_COUNT, DATA_W'(cols));
        write_register(REG_CLIP_LIMIT, DATA_W'(clip));
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t make_item(input logic [VAL_W-1:0] value, mean, sd,
                                        input logic has, last);
        item_t it;
        it.entry_value = value;
        it.row_mean    = mean;
        it.row_sd      = sd;
        it.has_entry   = has;
        it.row_end     = last;
        return it;
    endfunction

    // Q16.8 value biased toward zero, full scale, small values and single bits.
    function automatic logic [VAL_W-1:0] pick_q16();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return VAL_TOP;
        if (r < 5)
            return VAL_W'($urandom_range(255));
        if (r < 7)
            return VAL_W'(1) << $urandom_range(VAL_W - 1);
        return VAL_W'($urandom);
    endfunction

    // Keep many entries near the mean so that z is often below the clip bound.
    function automatic logic [VAL_W-1:0] pick_entry(input logic [VAL_W-1:0] mean);
        logic [VAL_W-1:0] mask;
        mask = (VAL_W'(1) << $urandom_range(VAL_W)) - 1'b1;
        if ($urandom_range(9) < 4)
            return mean ^ (VAL_W'($urandom) & mask);
        return pick_q16();
    endfunction

    function automatic logic [VAL_W-1:0] pick_sd();
        int unsigned r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        if (r < 4)
            return VAL_W'($urandom_range(1, 16));
        return pick_q16();
    endfunction

    // One row: mostly well formed, sometimes overfull, empty, or with a
    // mean and sd that drift between entries; stray markers mixed in.
    task automatic send_row();
        int unsigned      r;
        int unsigned      n_entries;
        int unsigned      cols_seen;
        int unsigned      k;
        logic [VAL_W-1:0] mean;
        logic [VAL_W-1:0] sd;
        bit               scrambled;
        bit               end_on_marker;
        cols_seen = (model_columns > MAX_COLUMNS_DEFAULT) ? MAX_COLUMNS_DEFAULT : model_columns;
        r = $urandom_range(99);
        if (r < 10)
        begin
            n_entries = 0;
        end
        else if (r < 22 && cols_seen <= 16)
        begin
            n_entries = cols_seen + $urandom_range(1, 2);
        end
        else if (r < 50 && cols_seen >= 1 && cols_seen <= 16)
        begin
            n_entries = cols_seen;
        end
        else
        begin
            n_entries = $urandom_range(1, (cols_seen >= 1 && cols_seen < 12) ? cols_seen : 12);
        end
        scrambled     = ($urandom_range(19) == 0);
        end_on_marker = (n_entries == 0) || ($urandom_range(3) == 0);
        mean          = pick_q16();
        sd            = pick_sd();
        for (k = 0; k < n_entries; k++)
        begin
            if ($urandom_range(11) == 0)
            begin
                send_item(make_item(pick_q16(), pick_q16(), pick_q16(), 1'b0, 1'b0));
            end
            if (scrambled)
            begin
                mean = pick_q16();
                sd   = pick_sd();
            end
            send_item(make_item(pick_entry(mean), mean, sd, 1'b1,
                                !end_on_marker && (k == n_entries - 1)));
        end
        if (end_on_marker)
        begin
            if (scrambled)
            begin
                mean = pick_q16();
                sd   = pick_sd();
            end
            send_item(make_item(pick_q16(), mean, sd, 1'b0, 1'b1));
        end
    endtask

    // Program one setting and stream random rows until enough entries went in;
    // optionally stall the sender halfway until all owed rows have come back.
    task automatic run_phase(input logic [COL_W-1:0] cols, input logic [CLIP_W-1:0] clip,
                             input int unsigned n_items, input bit pause_midway);
        int unsigned first_item;
        bit          paused;
        configure(cols, clip);
        first_item = items_sent;
        paused     = 1'b0;
        while (items_sent - first_item < n_items)
        begin
            send_row();
            if (pause_midway && !paused && (items_sent - first_item >= n_items / 2))
            begin
                wait_rows_done();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Three columns, widest clip: stray marker, zero sd, extreme fields,
    // a full row with no zero term, then an empty row whose zero term is zero.
    task automatic test_row_basics();
        configure(21'd3, CLIP_TOP);
        send_item(make_item(VAL_TOP, VAL_TOP, VAL_TOP, 1'b0, 1'b0));
        send_item(make_item(VAL_TOP, '0, '0, 1'b1, 1'b0));
        send_item(make_item('0, VAL_TOP, VAL_TOP, 1'b1, 1'b0));
        send_item(make_item(24'h800000, 24'h800000, 24'd1, 1'b1, 1'b1));
        send_item(make_item('0, '0, VAL_TOP, 1'b0, 1'b1));
    endtask

    // One column gives a zero result; zero columns flag every entry as excess.
    task automatic test_degenerate_columns();
        configure(21'd1, CLIP_RESET);
        send_item(make_item(24'h000100, 24'h000080, 24'h000010, 1'b1, 1'b0));
        send_item(make_item(VAL_TOP, 24'h000080, 24'h000010, 1'b1, 1'b1));
        configure('0, CLIP_RESET);
        send_item(make_item(24'h123456, 24'h000100, 24'h000100, 1'b1, 1'b1));
    endtask

    // Oversized column count with an empty row: the zero term overflows 64 bits.
    task automatic test_zero_term_saturation();
        configure(COLS_TOP, CLIP_TOP);
        send_item(make_item(VAL_TOP, VAL_TOP, '0, 1'b0, 1'b1));
    endtask

    // Two columns and seventeen full-scale z values push the result past 40 bits.
    task automatic test_result_saturation();
        int k;
        configure(21'd2, CLIP_TOP);
        for (k = 0; k < 17; k++)
        begin
            send_item(make_item(VAL_TOP, '0, 24'd1, 1'b1, k == 16));
        end
    endtask

    task automatic test_random_rows();
        run_phase(21'd4, 26'd131072, 140, 1'b0);
        run_phase(21'd8, 26'd185364, 140, 1'b0);
        run_phase(21'd1, CLIP_W'($urandom_range(0, CLIP_TOP)), 120, 1'b0);
        run_phase(21'd2, CLIP_TOP, 120, 1'b0);
        run_phase(21'd16, '0, 150, 1'b0);
        run_phase(COL_W'($urandom_range(3, 64)), CLIP_W'($urandom_range(0, CLIP_TOP)), 150, 1'b0);
        run_phase('0, CLIP_W'($urandom_range(0, CLIP_TOP)), 100, 1'b0);
        run_phase(COLS_TOP, CLIP_W'($urandom_range(0, CLIP_TOP)), 120, 1'b0);
        run_phase(COL_W'(MAX_COLUMNS_DEFAULT), CLIP_W'($urandom_range(0, CLIP_TOP)), 120, 1'b0);
        run_phase(21'd1000, 26'd2072430, 120, 1'b0);
    endtask

    // Back-to-back transactions on both sides for a long stretch.
    task automatic test_steady_stream();
        steady = 1'b1;
        run_phase(21'd6, 26'd160529, 200, 1'b0);
        steady = 1'b0;
    endtask

    // Sender holds off midway until the block has returned every row.
    task automatic test_drain_pause();
        run_phase(21'd5, 26'd146543, 100, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and the scoreboard
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each accepted result transaction with the oldest owed row.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("%0t: unexpected row result: expected none, actual variance %0h ovf %0b",
                             $time, result.row_variance, result.count_overflow);
                end
            end
            else
            begin
                oldest_row = pending_rows.pop_front();
                rows_checked++;
                if (result.row_variance !== oldest_row.row_variance)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("%0t: row_variance mismatch: expected %0h, actual %0h",
                                 $time, oldest_row.row_variance, result.row_variance);
                    end
                end
                if (result.count_overflow !== oldest_row.count_overflow)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("%0t: count_overflow mismatch: expected %0b, actual %0b",
                                 $time, oldest_row.count_overflow, result.count_overflow);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_row_basics();
        test_degenerate_columns();
        test_zero_term_saturation();
        test_result_saturation();
        test_random_rows();
        test_steady_stream();
        test_drain_pause();

        // Drain, then give trailing markers time to leave the pipeline.
        wait_rows_done();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d entries and row ends in %0d rows over %0d register settings.",
                 items_sent, rows_predicted, settings_used);
        $display("Rows with excess entries: %0d, saturated results: %0d, checked: %0d.",
                 overflow_rows, saturated_rows, rows_checked);
        if (mismatches == 0 && pending_rows.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #RUN_LIMIT;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
